>>> design/chp_pkg.sv
// Shared types, codes and constants for the cartridge header parser.
package chp_pkg;

	localparam int DATA_W = 8;
	localparam int SIZE_W = 24;
	localparam int POS_W = 4;
	localparam int OUT_TDATA_W = 48;

	// Header layout
	localparam logic [POS_W-1:0] POS_PRG = 4'd4;
	localparam logic [POS_W-1:0] POS_CHR = 4'd5;
	localparam logic [POS_W-1:0] POS_FLAGS6 = 4'd6;
	localparam logic [POS_W-1:0] POS_FLAGS7 = 4'd7;
	localparam logic [POS_W-1:0] POS_RAM = 4'd8;
	localparam logic [POS_W-1:0] POS_FLAGS9 = 4'd9;
	localparam logic [POS_W-1:0] POS_LAST = 4'd15;

	localparam logic [DATA_W-1:0] FLAGS7_RSVD_MASK = 8'h0E;
	localparam logic [DATA_W-1:0] FLAGS9_RSVD_MASK = 8'hFE;
	localparam logic [DATA_W-1:0] MAPPER_HI_MASK = 8'hF0;
	localparam logic [DATA_W-1:0] MAPPER_LO_MASK = 8'h0F;

	localparam logic [SIZE_W-1:0] HEADER_BYTES = 24'd16;

	// Configuration register indexes
	localparam logic CFG_PEDANTIC = 1'b0;
	localparam logic CFG_IMAGE_SIZE = 1'b1;

	// Error codes
	localparam logic [2:0] ERR_OK = 3'd0;
	localparam logic [2:0] ERR_SHORT = 3'd1;
	localparam logic [2:0] ERR_MAGIC = 3'd2;
	localparam logic [2:0] ERR_B7 = 3'd3;
	localparam logic [2:0] ERR_B9 = 3'd4;
	localparam logic [2:0] ERR_TAIL = 3'd5;
	localparam logic [2:0] ERR_SIZE = 3'd6;

	typedef struct packed {
		logic             pal_video;
		logic [7:0]       ram_banks;
		logic             arcade_system;
		logic [7:0]       mapper_number;
		logic             four_screen;
		logic             trainer_present;
		logic             battery_ram;
		logic             vertical_mirror;
		logic [7:0]       pattern_banks;
		logic [7:0]       program_banks;
		logic [2:0]       error_code;
		logic             header_ok;
	} chp_result_t;

	function automatic logic [DATA_W-1:0] magic_byte(input logic [1:0] idx);
		logic [DATA_W-1:0] m;
		case (idx)
			2'd0: m = 8'h4E;
			2'd1: m = 8'h45;
			2'd2: m = 8'h53;
			default: m = 8'h1A;
		endcase
		return m;
	endfunction

endpackage

>>> design/chp_parse.sv
// Header state registers and the per-byte decode and check logic.
module chp_parse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [chp_pkg::DATA_W-1:0]    data_byte,
	input  logic                          last_byte,
	input  logic                          pedantic_mode,
	input  logic [chp_pkg::SIZE_W-1:0]    image_size,
	output logic                          emit,
	output chp_pkg::chp_result_t          result
);

	logic [chp_pkg::POS_W-1:0]  pos_q;
	logic                       sent_q;
	logic [2:0]                 err_q;
	logic [7:0]                 prg_q, chr_q, flags6_q, flags7_q, ram_q, flags9_q;
	logic                       tail_q;

	logic [2:0]                 err_n;
	logic                       tail_n;
	logic [2:0]                 final_err;
	logic [2:0]                 code;
	logic [chp_pkg::SIZE_W-1:0] need;
	logic [7:0]                 mapper;

	always_comb begin
		err_n = err_q;
		tail_n = tail_q;
		unique case (pos_q) inside
			[4'd0:4'd3]: begin
				if (data_byte != chp_pkg::magic_byte(pos_q[1:0]) && err_q == chp_pkg::ERR_OK)
					err_n = chp_pkg::ERR_MAGIC;
			end
			chp_pkg::POS_PRG, chp_pkg::POS_CHR, chp_pkg::POS_FLAGS6, chp_pkg::POS_RAM: ;
			chp_pkg::POS_FLAGS7: begin
				if (pedantic_mode && (data_byte & chp_pkg::FLAGS7_RSVD_MASK) != '0 &&
				    err_q == chp_pkg::ERR_OK)
					err_n = chp_pkg::ERR_B7;
			end
			chp_pkg::POS_FLAGS9: begin
				if (pedantic_mode && (data_byte & chp_pkg::FLAGS9_RSVD_MASK) != '0 &&
				    err_q == chp_pkg::ERR_OK)
					err_n = chp_pkg::ERR_B9;
			end
			default: begin
				if (data_byte != '0)
					tail_n = 1'b1;
			end
		endcase
	end

	// Bank sizes are powers of two: shifts, one add chain, one compare
	assign need = chp_pkg::HEADER_BYTES
		+ {2'b00, prg_q, 14'd0}
		+ {3'b000, chr_q, 13'd0}
		+ {14'd0, flags6_q[2], 9'd0};

	always_comb begin
		if (err_n != chp_pkg::ERR_OK)
			final_err = err_n;
		else if (pedantic_mode && tail_n)
			final_err = chp_pkg::ERR_TAIL;
		else if (need > image_size)
			final_err = chp_pkg::ERR_SIZE;
		else
			final_err = chp_pkg::ERR_OK;
	end

	assign emit = !sent_q && (pos_q == chp_pkg::POS_LAST || last_byte);
	assign code = (pos_q == chp_pkg::POS_LAST) ? final_err : chp_pkg::ERR_SHORT;

	always_comb begin
		mapper = (flags6_q >> 4) | (flags7_q & chp_pkg::MAPPER_HI_MASK);
		if (tail_n)
			mapper = mapper & chp_pkg::MAPPER_LO_MASK;
		result = '0;
		result.error_code = code;
		if (code == chp_pkg::ERR_OK) begin
			result.header_ok = 1'b1;
			result.program_banks = prg_q;
			result.pattern_banks = chr_q;
			result.vertical_mirror = flags6_q[0];
			result.battery_ram = flags6_q[1];
			result.trainer_present = flags6_q[2];
			result.four_screen = flags6_q[3];
			result.mapper_number = mapper;
			result.arcade_system = flags7_q[0];
			result.ram_banks = (ram_q != '0) ? ram_q : 8'd1;
			result.pal_video = flags9_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sent_q <= 1'b0;
			err_q <= chp_pkg::ERR_OK;
			tail_q <= 1'b0;
			prg_q <= '0;
			chr_q <= '0;
			flags6_q <= '0;
			flags7_q <= '0;
			ram_q <= '0;
			flags9_q <= '0;
		end else if (advance) begin
			if (sent_q) begin
				// drop trailing bytes until the end of the image
				if (last_byte) begin
					pos_q <= '0;
					sent_q <= 1'b0;
					err_q <= chp_pkg::ERR_OK;
					tail_q <= 1'b0;
				end
			end else begin
				case (pos_q)
					chp_pkg::POS_PRG: prg_q <= data_byte;
					chp_pkg::POS_CHR: chr_q <= data_byte;
					chp_pkg::POS_FLAGS6: flags6_q <= data_byte;
					chp_pkg::POS_FLAGS7: flags7_q <= data_byte;
					chp_pkg::POS_RAM: ram_q <= data_byte;
					chp_pkg::POS_FLAGS9: flags9_q <= data_byte;
					default: ;
				endcase
				if (last_byte) begin
					pos_q <= '0;
					sent_q <= 1'b0;
					err_q <= chp_pkg::ERR_OK;
					tail_q <= 1'b0;
				end else if (pos_q == chp_pkg::POS_LAST) begin
					sent_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 4'd1;
					err_q <= err_n;
					tail_q <= tail_n;
				end
			end
		end
	end

endmodule

>>> design/chp_out_reg.sv
// Result register on the master-side stream.
module chp_out_reg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  chp_pkg::chp_result_t               result,
	input  logic                               taken,
	output logic                               valid,
	output logic [chp_pkg::OUT_TDATA_W-1:0]    data
);

	chp_pkg::chp_result_t res_q;
	logic                 valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (taken)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= result;
	end

	assign valid = valid_q;
	assign data = {(chp_pkg::OUT_TDATA_W - $bits(chp_pkg::chp_result_t))'(0), res_q};

endmodule

>>> design/cartridge_header_parser.sv
// Top level of the cartridge header parser: input register, config, parse, result.
//
// Streams a cartridge image in one byte per transaction and returns one result
// transaction per image: after the sixteenth header byte, or at an early tlast
// with the too-short error. Bytes past the header are dropped until tlast.
// The block takes one byte every cycle while not stalled; a byte waits in the
// input register, and when the input stage advances its result, if any, is
// loaded into the output register, which raises m_tvalid. The only stall comes
// from m_tready: with the result register full and not taken, the input
// register holds. Write pedantic_mode and image_size while the stream is idle.
module cartridge_header_parser (
	input  logic                               clk,
	input  logic                               arst_n,
	// s_tdata: [7:0] data_byte
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,
	input  logic                               s_tlast,
	// m_tdata: [0] header_ok, [3:1] error_code, [11:4] program_banks,
	// [19:12] pattern_banks, [20] vertical_mirror, [21] battery_ram,
	// [22] trainer_present, [23] four_screen, [31:24] mapper_number,
	// [32] arcade_system, [40:33] ram_banks, [41] pal_video, [47:42] zero
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [chp_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [chp_pkg::SIZE_W-1:0]         cfg_data
);

	logic                           valid_s1;
	logic [chp_pkg::DATA_W-1:0]     byte_s1;
	logic                           last_s1;
	logic                           advance;
	logic                           emit;
	logic                           pedantic_q;
	logic [chp_pkg::SIZE_W-1:0]     size_q;
	chp_pkg::chp_result_t           result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pedantic_q <= 1'b0;
			size_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				chp_pkg::CFG_PEDANTIC: pedantic_q <= cfg_data[0];
				chp_pkg::CFG_IMAGE_SIZE: size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the input stage whenever the result register can take a result
	assign advance = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	chp_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.data_byte     (byte_s1),
		.last_byte     (last_s1),
		.pedantic_mode (pedantic_q),
		.image_size    (size_q),
		.emit          (emit),
		.result        (result)
	);

	chp_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && emit),
		.result (result),
		.taken  (m_tready),
		.valid  (m_tvalid),
		.data   (m_tdata)
	);

endmodule
